[src/dmm_pkg.sv]
// Shared types and constants for the dense matrix multiply block.
// Used by every module in src but dmm_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dmm_pkg;

    // field widths
    localparam int ELEM_W  = 16;              // Q1.15 element
    localparam int PROD_W  = 2 * ELEM_W;      // full product
    localparam int SUM_W   = 36;              // Q6.30 dot product
    localparam int OP_W    = 2;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_MAX_W = ROW_W + COL_W;

    // op codes of an input word
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
    localparam logic [CFG_W-1:0]     CFG_RESET     = 4'd8;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [ELEM_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic [COL_W-1:0]        out_col;
        logic signed [SUM_W-1:0] product_sum;
        logic                    last;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_RUN
    } cmd_kind_t;

    // classified command; dims are already saturated and nonzero on a run
    typedef struct packed {
        cmd_kind_t                kind;
        logic [ADDR_MAX_W-1:0]    addr;
        logic signed [ELEM_W-1:0] value;
        logic [CFG_W-1:0]         m;
        logic [CFG_W-1:0]         kd;
        logic [CFG_W-1:0]         p;
    } cmd_t;

    // store access from the back end
    typedef struct packed {
        logic                     a_we;
        logic                     b_we;
        logic [ADDR_MAX_W-1:0]    waddr;
        logic signed [ELEM_W-1:0] wdata;
        logic [ADDR_MAX_W-1:0]    a_raddr;
        logic [ADDR_MAX_W-1:0]    b_raddr;
    } ram_req_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ISSUE,
        B_DRAIN,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

[src/dmm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/dmm_front.sv]
// Front end: accepts input words, drops no-op words, resolves store addresses
// and run dimensions, and queues commands for the back end. Uses dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmm_front #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cmd_valid,
    output logic                         cmd_ready,
    input  wire dmm_pkg::in_word_t       cmd,
    input  wire logic [dmm_pkg::CFG_W-1:0] rows_a,
    input  wire logic [dmm_pkg::CFG_W-1:0] inner_dim,
    input  wire logic [dmm_pkg::CFG_W-1:0] cols_b,
    output logic                         q_valid,
    output dmm_pkg::cmd_t                q_cmd,
    input  wire logic                    q_pop
);

    import dmm_pkg::*;

    cmd_t              q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;

    cmd_t             entry;
    logic             keep;
    logic             in_range;
    logic             push;
    logic [CFG_W-1:0] m_sat, kd_sat, p_sat;

    // saturate dimensions at MAX_DIM
    always_comb
    begin
        m_sat  = (int'(rows_a)    > MAX_DIM) ? CFG_W'(MAX_DIM) : rows_a;
        kd_sat = (int'(inner_dim) > MAX_DIM) ? CFG_W'(MAX_DIM) : inner_dim;
        p_sat  = (int'(cols_b)    > MAX_DIM) ? CFG_W'(MAX_DIM) : cols_b;
    end

    // classify the incoming word
    always_comb
    begin
        in_range    = (int'(cmd.row) < MAX_DIM) && (int'(cmd.col) < MAX_DIM);
        entry.addr  = ADDR_MAX_W'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
        entry.value = cmd.value;
        entry.m     = m_sat;
        entry.kd    = kd_sat;
        entry.p     = p_sat;
        entry.kind  = CMD_RUN;
        keep        = 1'b0;
        unique case (cmd.op)
            OP_LOAD_A:
            begin
                entry.kind = CMD_LOAD_A;
                keep       = in_range;
            end
            OP_LOAD_B:
            begin
                entry.kind = CMD_LOAD_B;
                keep       = in_range;
            end
            OP_RUN:
            begin
                entry.kind = CMD_RUN;
                keep       = (m_sat != '0) && (kd_sat != '0) && (p_sat != '0);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // queue control
    always_comb
    begin
        cmd_ready   = (count_reg != (Q_PTR_W + 1)'(Q_DEPTH));
        q_valid     = (count_reg != '0);
        q_cmd       = q_mem_reg[rd_ptr_reg];
        push        = cmd_valid && cmd_ready && keep;
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

[src/dmm_back.sv]
// Back end: executes queued commands; writes the stores on loads, walks one
// multiply-accumulate per cycle on runs, pausing per result. Uses dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmm_back #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire dmm_pkg::cmd_t                 q_cmd,
    output logic                               q_pop,
    output dmm_pkg::ram_req_t                  ram_req,
    input  wire logic signed [dmm_pkg::ELEM_W-1:0] a_rdata,
    input  wire logic signed [dmm_pkg::ELEM_W-1:0] b_rdata,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output dmm_pkg::out_word_t                 res
);

    import dmm_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    back_state_t state_reg, state_next;

    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [DIM_W-1:0] m_reg, m_next;
    logic [DIM_W-1:0] kd_reg, kd_next;
    logic [DIM_W-1:0] p_reg, p_next;

    logic                     rd_vld_reg, rd_first_reg;
    logic                     prod_vld_reg, prod_first_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     res_valid_reg, res_valid_next;
    out_word_t                res_reg;

    logic last_i, last_j, last_k;
    logic res_free, emit, issue, start_run;

    always_comb
    begin
        last_i    = (DIM_W'(i_reg) == m_reg - 1'b1);
        last_j    = (DIM_W'(j_reg) == p_reg - 1'b1);
        last_k    = (DIM_W'(k_reg) == kd_reg - 1'b1);
        res_free  = !res_valid_reg || res_ready;
        issue     = (state_reg == B_ISSUE);
        emit      = (state_reg == B_EMIT) && res_free;
        q_pop     = (state_reg == B_IDLE) && q_valid;
        start_run = q_pop && (q_cmd.kind == CMD_RUN);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (start_run)
                begin
                    state_next = B_ISSUE;
                end
            end
            B_ISSUE:
            begin
                if (last_k)
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (res_free)
                begin
                    state_next = (last_i && last_j) ? B_IDLE : B_ISSUE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // counters, store access and result capture
    always_comb
    begin
        i_next  = i_reg;
        j_next  = j_reg;
        k_next  = k_reg;
        m_next  = m_reg;
        kd_next = kd_reg;
        p_next  = p_reg;

        ram_req.a_we    = q_pop && (q_cmd.kind == CMD_LOAD_A);
        ram_req.b_we    = q_pop && (q_cmd.kind == CMD_LOAD_B);
        ram_req.waddr   = q_cmd.addr;
        ram_req.wdata   = q_cmd.value;
        ram_req.a_raddr = ADDR_MAX_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
        ram_req.b_raddr = ADDR_MAX_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

        if (start_run)
        begin
            m_next  = DIM_W'(q_cmd.m);
            kd_next = DIM_W'(q_cmd.kd);
            p_next  = DIM_W'(q_cmd.p);
            i_next  = '0;
            j_next  = '0;
            k_next  = '0;
        end

        if (issue)
        begin
            k_next = last_k ? '0 : k_reg + 1'b1;
        end

        // row-major walk over the result
        if (emit)
        begin
            if (last_j)
            begin
                j_next = '0;
                i_next = i_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end

        res_valid_next = emit ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            kd_reg        <= '0;
            p_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_first_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            kd_reg        <= kd_next;
            p_reg         <= p_next;
            rd_vld_reg    <= issue;
            rd_first_reg  <= issue && (k_reg == '0);
            prod_vld_reg  <= rd_vld_reg;
            prod_first_reg <= rd_first_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    // multiply, then accumulate; first term of a dot product restarts the sum
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a_rdata) * PROD_W'(b_rdata);
        if (prod_vld_reg)
        begin
            acc_reg <= prod_first_reg ? SUM_W'(prod_reg) : acc_reg + SUM_W'(prod_reg);
        end
        if (emit)
        begin
            res_reg.out_row     <= ROW_W'(i_reg);
            res_reg.out_col     <= COL_W'(j_reg);
            res_reg.product_sum <= acc_reg;
            res_reg.last        <= last_i && last_j;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[src/dense_matrix_multiply.sv]
// Top level of the dense matrix multiply block: configuration registers,
// front end, back end and the two element stores. Uses dmm_pkg and all modules in src.
`timescale 1ns / 1ps
`default_nettype none

// Computes C = A x B on signed Q1.15 elements with exact signed Q6.30 sums.
// A load word (op 0 or 1) writes one element of A or B; a run word (op 2)
// emits every element of C in row-major order with last on the final one.
// Words enter a four-deep command queue, so the input keeps taking words
// while a run is being worked on, until the queue is full. The back end
// writes a load into its store as it pops it from the queue. On a run it
// takes the run word from the queue, then a single multiply-accumulate unit
// reads one element of A and one of B per cycle while it issues the terms
// of a result element; each sum then drains through the read and multiply
// registers and is loaded into the output register once the output is free.
// Dimensions above MAX_DIM saturate;
// a run with a zero dimension, op 3 and out-of-range writes do nothing.
// Configuration is sampled when a run word is accepted.
module dense_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_ready,
    input  wire dmm_pkg::in_word_t            cmd,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output dmm_pkg::out_word_t                res,
    input  wire logic                         cfg_we,
    input  wire logic [dmm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dmm_pkg::CFG_W-1:0]    cfg_data
);

    import dmm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;

    logic        q_valid;
    logic        q_pop;
    cmd_t        q_cmd;
    ram_req_t    ram_req;
    logic [ELEM_W-1:0] a_rdata, b_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_RESET;
            inner_dim_reg <= CFG_RESET;
            cols_b_reg    <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROWS_A)
            begin
                rows_a_reg <= cfg_data;
            end
            if (cfg_index == CFG_INNER_DIM)
            begin
                inner_dim_reg <= cfg_data;
            end
            if (cfg_index == CFG_COLS_B)
            begin
                cols_b_reg <= cfg_data;
            end
        end
    end

    dmm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rows_a    (rows_a_reg),
        .inner_dim (inner_dim_reg),
        .cols_b    (cols_b_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    dmm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .ram_req   (ram_req),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // A store
    dmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (ram_req.a_we),
        .waddr (ram_req.waddr[ADDR_W-1:0]),
        .wdata (ram_req.wdata),
        .raddr (ram_req.a_raddr[ADDR_W-1:0]),
        .rdata (a_rdata)
    );

    // B store
    dmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (ram_req.b_we),
        .waddr (ram_req.waddr[ADDR_W-1:0]),
        .wdata (ram_req.wdata),
        .raddr (ram_req.b_raddr[ADDR_W-1:0]),
        .rdata (b_rdata)
    );

`ifndef SYNTHESIS
    // a load writes exactly one store
    a_one_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.a_we && ram_req.b_we))
        else $error("both stores written in one cycle");

    // store writes only come from a queued command
    a_write_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.a_we || ram_req.b_we) |-> q_valid)
        else $error("store write with empty command queue");

    // a full queue always has a command for the back end
    a_full_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> q_valid)
        else $error("input stalled with empty command queue");

    // a pop never coincides with a result being built: results follow a run
    a_pop_not_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_cmd.kind == CMD_RUN) |=> !(res_valid && !$past(res_valid)))
        else $error("result appeared right after a run was started");
`endif

endmodule

`default_nettype wire
